// ===== design/fsdc_pkg.sv =====
// ----------------------------------------------------------------------------
// fsdc_pkg - fan speed deadband controller package
// Shared types, command codes, register indexes and constants.
// ----------------------------------------------------------------------------
package fsdc_pkg;

    // command codes of an input item
    typedef enum logic [2:0] {
        CMD_PULSE    = 3'd0,
        CMD_WINDOW   = 3'd1,
        CMD_CORRECT  = 3'd2,
        CMD_ENCODER  = 3'd3,
        CMD_SET_REF  = 3'd4,
        CMD_FFWD     = 3'd5
    } cmd_t;

    // configuration register indexes (byte address = 4 * index)
    typedef enum logic [1:0] {
        REG_DEADBAND  = 2'd0,
        REG_PWM_MAX   = 2'd1,
        REG_ENC_STEP  = 2'd2,
        REG_ENC_LIMIT = 2'd3
    } reg_idx_t;

    localparam int unsigned APB_AW = 4;
    localparam int unsigned APB_DW = 32;

    // field widths
    localparam int unsigned CMD_W   = 3;
    localparam int unsigned REF_W   = 16;
    localparam int unsigned DUTY_W  = 10;
    localparam int unsigned RPM_W   = 17;
    localparam int unsigned COUNT_W = 12;

    // register reset values
    localparam logic [9:0]  DEADBAND_RST  = 10'd40;
    localparam logic [9:0]  PWM_MAX_RST   = 10'd1000;
    localparam logic [9:0]  ENC_STEP_RST  = 10'd100;
    localparam logic [15:0] ENC_LIMIT_RST = 16'd7900;

    // datapath constants
    localparam logic [COUNT_W-1:0] PULSE_MAX   = 12'd4095;
    localparam logic [RPM_W-1:0]   RPM_MAX     = 17'd122850;
    localparam logic [REF_W-1:0]   REF_MAX     = 16'hFFFF;
    localparam logic [REF_W-1:0]   FF_LOW_REF  = 16'd240;
    localparam logic [REF_W-1:0]   FF_HIGH_REF = 16'd8000;
    localparam logic [DUTY_W-1:0]  FF_LOW_DUTY = 10'd1000;
    localparam logic [19:0]        FF_OFFSET   = 20'd83329;
    localparam logic [13:0]        FF_MUL      = 14'd12527;
    localparam int unsigned        FF_SHIFT    = 20;

    typedef struct packed {
        logic [9:0]  deadband;
        logic [9:0]  pwm_max;
        logic [9:0]  encoder_step;
        logic [15:0] encoder_limit;
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             enc_direction;
        logic [REF_W-1:0] new_reference;
    } req_item_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [RPM_W-1:0]  measured_rpm;
        logic [REF_W-1:0]  reference_rpm;
    } rsp_item_t;

endpackage

// ===== design/fsdc_req_if.sv =====
// ----------------------------------------------------------------------------
// fsdc_req_if - command channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface fsdc_req_if;
    import fsdc_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic             enc_direction;
    logic [REF_W-1:0] new_reference;

    modport source (output valid, cmd, enc_direction, new_reference, input ready);
    modport sink   (input valid, cmd, enc_direction, new_reference, output ready);
endinterface

// ===== design/fsdc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// fsdc_rsp_if - result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface fsdc_rsp_if;
    import fsdc_pkg::*;

    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty;
    logic [RPM_W-1:0]  measured_rpm;
    logic [REF_W-1:0]  reference_rpm;

    modport source (output valid, duty, measured_rpm, reference_rpm, input ready);
    modport sink   (input valid, duty, measured_rpm, reference_rpm, output ready);
endinterface

// ===== design/fsdc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// fsdc_cfg_regs - configuration registers
// APB-style register file for deadband, duty limit and encoder settings.
// ----------------------------------------------------------------------------
module fsdc_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fsdc_pkg::APB_AW-1:0]  paddr,
    input  logic [fsdc_pkg::APB_DW-1:0]  pwdata,
    output logic [fsdc_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output fsdc_pkg::cfg_t               cfg
);
    import fsdc_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_DEADBAND:  cfg_next.deadband      = pwdata[9:0];
                REG_PWM_MAX:   cfg_next.pwm_max       = pwdata[9:0];
                REG_ENC_STEP:  cfg_next.encoder_step  = pwdata[9:0];
                REG_ENC_LIMIT: cfg_next.encoder_limit = pwdata[15:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadband      <= DEADBAND_RST;
            cfg_reg.pwm_max       <= PWM_MAX_RST;
            cfg_reg.encoder_step  <= ENC_STEP_RST;
            cfg_reg.encoder_limit <= ENC_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_DEADBAND:  prdata = APB_DW'(cfg_reg.deadband);
            REG_PWM_MAX:   prdata = APB_DW'(cfg_reg.pwm_max);
            REG_ENC_STEP:  prdata = APB_DW'(cfg_reg.encoder_step);
            REG_ENC_LIMIT: prdata = APB_DW'(cfg_reg.encoder_limit);
            default:       prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

    // untouched registers hold over a write to another index
    a_dead_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && idx != REG_DEADBAND) |=> $stable(cfg_reg.deadband))
        else $error("deadband changed by a write to another register");
    a_wr_take: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && idx == REG_ENC_LIMIT) |=> cfg_reg.encoder_limit == $past(pwdata[15:0]))
        else $error("encoder limit write lost");
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !wr_en |=> $stable(cfg_reg))
        else $error("configuration changed without a write");

endmodule

// ===== design/fsdc_core.sv =====
// ----------------------------------------------------------------------------
// fsdc_core - controller state and command datapath
// Holds pulse count, rpm, reference and duty; applies one command per cycle while en is high.
// ----------------------------------------------------------------------------
module fsdc_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  fsdc_pkg::req_item_t  item,
    input  fsdc_pkg::cfg_t       cfg,
    output fsdc_pkg::rsp_item_t  result
);
    import fsdc_pkg::*;

    logic [COUNT_W-1:0] pulse_count_reg, pulse_count_next;
    logic [RPM_W-1:0]   rpm_now_reg,     rpm_now_next;
    logic [REF_W-1:0]   rpm_target_reg,  rpm_target_next;
    logic [DUTY_W-1:0]  duty_reg,        duty_next;

    logic [RPM_W-1:0]   rpm_latch;
    logic [17:0]        upper_bound;
    logic [17:0]        actual_plus_db;
    logic               too_fast;
    logic               too_slow;
    logic [RPM_W-1:0]   enc_sum;
    logic [REF_W-1:0]   enc_up;
    logic [REF_W-1:0]   enc_down;
    logic [19:0]        ref_x10;
    logic [RPM_W-1:0]   ff_diff;
    logic [30:0]        ff_prod;
    logic [DUTY_W-1:0]  ff_duty;

    // count * 30 = count * 32 - count * 2
    assign rpm_latch = RPM_W'({pulse_count_reg, 5'b0}) - RPM_W'({pulse_count_reg, 1'b0});

    // lower bound kept unsigned: actual < target - db  <=>  actual + db < target
    assign upper_bound    = 18'(rpm_target_reg) + 18'(cfg.deadband);
    assign actual_plus_db = 18'(rpm_now_reg) + 18'(cfg.deadband);
    assign too_fast       = 18'(rpm_now_reg) > upper_bound;
    assign too_slow       = actual_plus_db < 18'(rpm_target_reg);

    assign enc_sum  = RPM_W'(rpm_target_reg) + RPM_W'(cfg.encoder_step);
    assign enc_up   = enc_sum[RPM_W-1] ? REF_MAX : enc_sum[REF_W-1:0];
    assign enc_down = (rpm_target_reg > REF_W'(cfg.encoder_step))
                    ? rpm_target_reg - REF_W'(cfg.encoder_step) : '0;

    // feedforward: ((83329 - 10*ref) * 12527) >> 20, ref within 240..8000
    assign ref_x10 = 20'({rpm_target_reg, 3'b000}) + 20'({rpm_target_reg, 1'b0});
    assign ff_diff = RPM_W'(FF_OFFSET - ref_x10);
    assign ff_prod = 31'(ff_diff) * 31'(FF_MUL);
    assign ff_duty = ff_prod[FF_SHIFT +: DUTY_W];

    always_comb
    begin
        pulse_count_next = pulse_count_reg;
        rpm_now_next     = rpm_now_reg;
        rpm_target_next  = rpm_target_reg;
        duty_next        = duty_reg;
        case (cmd_t'(item.cmd))
            CMD_PULSE:
            begin
                if (pulse_count_reg != PULSE_MAX)
                    pulse_count_next = pulse_count_reg + 1'b1;
            end
            CMD_WINDOW:
            begin
                rpm_now_next     = rpm_latch;
                pulse_count_next = '0;
            end
            CMD_CORRECT:
            begin
                if (too_fast)
                begin
                    if (duty_reg < cfg.pwm_max)
                        duty_next = duty_reg + 1'b1;
                end
                else if (too_slow)
                begin
                    if (duty_reg != '0)
                        duty_next = duty_reg - 1'b1;
                end
            end
            CMD_ENCODER:
            begin
                if (item.enc_direction)
                begin
                    if (rpm_target_reg < cfg.encoder_limit)
                        rpm_target_next = enc_up;
                end
                else
                begin
                    rpm_target_next = enc_down;
                end
            end
            CMD_SET_REF:
            begin
                rpm_target_next = item.new_reference;
            end
            CMD_FFWD:
            begin
                if (rpm_target_reg < FF_LOW_REF)
                    duty_next = FF_LOW_DUTY;
                else if (rpm_target_reg > FF_HIGH_REF)
                    duty_next = '0;
                else
                    duty_next = ff_duty;
            end
            default:
            begin
                pulse_count_next = pulse_count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_count_reg <= '0;
            rpm_now_reg     <= '0;
            rpm_target_reg  <= '0;
            duty_reg        <= '0;
        end
        else if (en)
        begin
            pulse_count_reg <= pulse_count_next;
            rpm_now_reg     <= rpm_now_next;
            rpm_target_reg  <= rpm_target_next;
            duty_reg        <= duty_next;
        end
    end

    assign result.duty          = duty_next;
    assign result.measured_rpm  = rpm_now_next;
    assign result.reference_rpm = rpm_target_next;

    a_rpm_range: assert property (@(posedge clk) disable iff (!rst_n)
        rpm_now_reg <= RPM_MAX)
        else $error("latched rpm out of range");
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(pulse_count_reg) && $stable(rpm_now_reg)
                 && $stable(rpm_target_reg) && $stable(duty_reg)))
        else $error("state moved without a command");
    a_window_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (en && item.cmd == CMD_WINDOW) |=> pulse_count_reg == '0)
        else $error("pulse count not cleared at window end");

endmodule

// ===== design/fan_speed_deadband_controller.sv =====
// ----------------------------------------------------------------------------
// fan_speed_deadband_controller - fan speed controller with deadband
// Tacho counting, rpm latch, deadband duty nudging, encoder reference and
// feedforward duty preset behind valid/ready channels and an APB port.
// ----------------------------------------------------------------------------
// Path: an accepted item waits in the command register, executes when the
//   result stage is free or being drained, and its result is registered for rsp.
// Throughput: one item per cycle unless rsp stalls; command register and
//   result register are separate, so a new item is taken while a result waits on rsp.
// The state update (one 17x14 multiply for feedforward) sits between them.
// Reset (rst_n low, async): state cleared to zero, registers to defaults,
//   both stages empty.
module fan_speed_deadband_controller (
    input  logic                         clk,
    input  logic                         rst_n,
    fsdc_req_if.sink                     req,
    fsdc_rsp_if.source                   rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fsdc_pkg::APB_AW-1:0]  paddr,
    input  logic [fsdc_pkg::APB_DW-1:0]  pwdata,
    output logic [fsdc_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import fsdc_pkg::*;

    cfg_t       cfg;
    req_item_t  req_item;

    // command stage
    logic       in_vld_reg, in_vld_next;
    req_item_t  in_item_reg;

    // result stage
    logic       out_vld_reg, out_vld_next;
    rsp_item_t  out_item_reg;
    rsp_item_t  core_result;

    logic       req_fire;
    logic       exec_fire;

    fsdc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // an item executes when the result stage is free or being drained
    assign exec_fire = in_vld_reg && (!out_vld_reg || rsp.ready);
    assign req.ready = !in_vld_reg || exec_fire;
    assign req_fire  = req.valid && req.ready;

    assign req_item.cmd           = req.cmd;
    assign req_item.enc_direction = req.enc_direction;
    assign req_item.new_reference = req.new_reference;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (req_fire)
            in_vld_next = 1'b1;
        else if (exec_fire)
            in_vld_next = 1'b0;
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (exec_fire)
            out_vld_next = 1'b1;
        else if (rsp.ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (req_fire)
            in_item_reg <= req_item;
        if (exec_fire)
            out_item_reg <= core_result;
    end

    fsdc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (exec_fire),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    assign rsp.valid         = out_vld_reg;
    assign rsp.duty          = out_item_reg.duty;
    assign rsp.measured_rpm  = out_item_reg.measured_rpm;
    assign rsp.reference_rpm = out_item_reg.reference_rpm;

    // an accepted item never overwrites one still waiting to execute
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |-> (!in_vld_reg || exec_fire))
        else $error("command stage overrun");
    // an executed item always shows up as a result next cycle
    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> rsp.valid)
        else $error("executed item produced no result");
    // a pending result is never replaced before it is taken
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !rsp.ready) |-> !exec_fire)
        else $error("result overwritten while stalled");

endmodule
